/* rtl/nrbf_pkg.sv */
// ----------------------------------------------------------------------------
// nrbf_pkg: shared types and constants
// Field widths, opcodes, fixed-point constants, the 2^(-k/8) table and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package nrbf_pkg;

  localparam int DEF_MAX_KERNELS = 32;

  localparam int OPCODE_W = 1;
  localparam int KIDX_W   = 5;
  localparam int CENTER_W = 16;
  localparam int HWIDTH_W = 24;
  localparam int WEIGHT_W = 32;
  localparam int PHASE_W  = 16;
  localparam int FORCE_W  = 32;
  localparam int ASUM_W   = 22;
  localparam int ACTK_W   = 6;

  // activation is unsigned Q1.16 with value up to 1.0
  localparam int PSI_W    = 17;
  // signed psi * weight product
  localparam int PROD_W   = PSI_W + 1 + WEIGHT_W;
  localparam int ENTRY_W  = CENTER_W + HWIDTH_W + WEIGHT_W;

  localparam logic [ACTK_W-1:0] ACTIVE_RESET = ACTK_W'(32);

  localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_EVAL = 1'b1;

  // log2(e) in Q.16
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  // integer exponent at which the activation flushes to zero
  localparam logic [18:0] FLUSH_SHIFT = 19'd17;

  typedef struct packed {
    logic load_we;      // write one kernel entry
    logic eval_start;   // capture phase, clear accumulators
    logic issue;        // read one kernel entry into the pipeline
    logic div_start;    // load divider from accumulators
    logic div_step;     // one quotient bit
    logic result_load;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;   // no kernel in flight
  } stat_t;

  // round(2^(-k/8) * 65536), k = 0..8
  function automatic logic [PSI_W-1:0] pow2_val(input logic [3:0] k);
    logic [PSI_W-1:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd60097;
      4'd2:    v = 17'd55109;
      4'd3:    v = 17'd50535;
      4'd4:    v = 17'd46341;
      4'd5:    v = 17'd42495;
      4'd6:    v = 17'd38968;
      4'd7:    v = 17'd35734;
      4'd8:    v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

/* rtl/normalized_rbf_forcing_term.sv */
// ----------------------------------------------------------------------------
// normalized_rbf_forcing_term: normalized Gaussian RBF forcing term
// Kernel table with per-kernel center, inverse width and weight; an evaluate
// transaction returns the activation-weighted mean weight and activation sum.
// ----------------------------------------------------------------------------
// A load transaction (opcode 0) writes one kernel entry and gives no result.
// An evaluate transaction (opcode 1) reads the first K entries, K =
// min(active_kernels, MAX_KERNELS), one per cycle through an 8-stage
// activation pipeline, then runs a restoring divider that produces one
// quotient bit per cycle over the full accumulator width (55 bits at 32
// kernels). The time an evaluate occupies the block is set by the kernel
// read port and the serial divider. Results sit in an output register, so
// new transactions are taken while a result waits to be read.
// Entries must be loaded before an evaluate uses them; active_kernels is
// written only while the block is idle.
// ----------------------------------------------------------------------------
module normalized_rbf_forcing_term #(
  parameter int MAX_KERNELS = nrbf_pkg::DEF_MAX_KERNELS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [nrbf_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic [nrbf_pkg::KIDX_W-1:0]          in_kernel_index,
  input  logic [nrbf_pkg::CENTER_W-1:0]        in_center,
  input  logic [nrbf_pkg::HWIDTH_W-1:0]        in_width,
  input  logic signed [nrbf_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [nrbf_pkg::PHASE_W-1:0]         in_phase,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [nrbf_pkg::FORCE_W-1:0]  out_force_res,
  output logic [nrbf_pkg::ASUM_W-1:0]          out_activation_sum,
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nrbf_pkg::ACTK_W-1:0]          cfg_active_kernels
);
  import nrbf_pkg::*;

  localparam int KI_W = $clog2(MAX_KERNELS);

  // command and status between sequencer and datapath
  cmd_t            cmd;
  stat_t           stat;
  logic [KI_W-1:0] rd_addr;

  // sequencer: handshakes, kernel walk, divider step count
  nrbf_ctrl #(
    .MAX_KERNELS (MAX_KERNELS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_kernel_index    (in_kernel_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_kernels (cfg_active_kernels),
    .cmd                (cmd),
    .rd_addr            (rd_addr),
    .stat               (stat)
  );

  // kernel table, activation pipeline, accumulators and divider
  nrbf_datapath #(
    .MAX_KERNELS (MAX_KERNELS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .rd_addr            (rd_addr),
    .stat               (stat),
    .in_kernel_index    (in_kernel_index),
    .in_center          (in_center),
    .in_width           (in_width),
    .in_weight          (in_weight),
    .in_phase           (in_phase),
    .out_force_res      (out_force_res),
    .out_activation_sum (out_activation_sum)
  );

endmodule

/* rtl/nrbf_ctrl.sv */
// ----------------------------------------------------------------------------
// nrbf_ctrl: sequencing controller
// Accepts transactions, walks the kernel table, waits for the pipeline to
// drain, runs the serial divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module nrbf_ctrl #(
  parameter int MAX_KERNELS = nrbf_pkg::DEF_MAX_KERNELS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [nrbf_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [nrbf_pkg::KIDX_W-1:0]         in_kernel_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nrbf_pkg::ACTK_W-1:0]         cfg_active_kernels,
  output nrbf_pkg::cmd_t                      cmd,
  output logic [$clog2(MAX_KERNELS)-1:0]      rd_addr,
  input  nrbf_pkg::stat_t                     stat
);
  import nrbf_pkg::*;

  localparam int KI_W   = $clog2(MAX_KERNELS);
  localparam int CNT_W  = $clog2(MAX_KERNELS + 1);
  localparam int NUM_W  = PROD_W + KI_W;
  localparam int DIV_CW = $clog2(NUM_W + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_CW-1:0] div_cnt_r, div_cnt_nxt;
  logic [ACTK_W-1:0] active_r, active_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign rd_addr   = idx_r[KI_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    div_cnt_nxt   = div_cnt_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (cfg_valid && cfg_ready) begin
      active_nxt = cfg_active_kernels;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load_we = (32'(in_kernel_index) < MAX_KERNELS);
          end else begin
            cmd.eval_start = 1'b1;
            idx_nxt        = '0;
            if (32'(active_r) > MAX_KERNELS) begin
              cnt_nxt = CNT_W'(MAX_KERNELS);
            end else begin
              cnt_nxt = CNT_W'(active_r);
            end
            // no kernels: straight to the (empty) drain
            if (32'(active_r) == 0) begin
              state_nxt = ST_DRAIN;
            end else begin
              state_nxt = ST_ISSUE;
            end
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        idx_nxt   = idx_r + CNT_W'(1);
        if (idx_r + CNT_W'(1) == cnt_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          cmd.div_start = 1'b1;
          div_cnt_nxt   = '0;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DIV_CW'(1);
        if (div_cnt_r == DIV_CW'(NUM_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.result_load = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      div_cnt_r   <= '0;
      active_r    <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/nrbf_datapath.sv */
// ----------------------------------------------------------------------------
// nrbf_datapath: kernel table, activation pipeline, accumulators, divider
// Streams one kernel per cycle through the exponent pipeline, sums activations
// and weighted activations, then divides one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nrbf_datapath #(
  parameter int MAX_KERNELS = nrbf_pkg::DEF_MAX_KERNELS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nrbf_pkg::cmd_t                      cmd,
  input  logic [$clog2(MAX_KERNELS)-1:0]      rd_addr,
  output nrbf_pkg::stat_t                     stat,
  input  logic [nrbf_pkg::KIDX_W-1:0]         in_kernel_index,
  input  logic [nrbf_pkg::CENTER_W-1:0]       in_center,
  input  logic [nrbf_pkg::HWIDTH_W-1:0]       in_width,
  input  logic signed [nrbf_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [nrbf_pkg::PHASE_W-1:0]        in_phase,
  output logic signed [nrbf_pkg::FORCE_W-1:0] out_force_res,
  output logic [nrbf_pkg::ASUM_W-1:0]         out_activation_sum
);
  import nrbf_pkg::*;

  localparam int KI_W  = $clog2(MAX_KERNELS);
  localparam int NUM_W = PROD_W + KI_W;
  localparam int SUM_W = $clog2(MAX_KERNELS * 65536 + 1);
  localparam int DEN_W = SUM_W + 1;
  localparam int NSTG  = 8;

  localparam logic [NUM_W-1:0] Q_POS_LIM = NUM_W'(64'h0000_0000_7FFF_FFFF);
  localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(64'h0000_0000_8000_0000);

  // kernel table
  logic [ENTRY_W-1:0] kmem [MAX_KERNELS];
  logic [ENTRY_W-1:0] rd_q;
  logic [KI_W-1:0]    wr_addr;

  logic [PHASE_W-1:0] phase_r;
  logic [NSTG-1:0]    vld_r;

  // stage registers
  logic [15:0]                ad1_r;
  logic [HWIDTH_W-1:0]        h1_r, h2_r;
  logic signed [WEIGHT_W-1:0] w1_r, w2_r, w3_r, w4_r, w5_r, w6_r;
  logic [31:0]                d2_r;
  logic [33:0]                a3_r;
  logic                       fl4_r, fl5_r;
  logic [4:0]                 n4_r, n5_r;
  logic [15:0]                r4_r;
  logic [PSI_W-1:0]           ti5_r, sub5_r, psi6_r, psi7_r;
  logic signed [PROD_W-1:0]   pw7_r;

  logic signed [NUM_W-1:0]    num_r;
  logic [SUM_W-1:0]           sum_r;

  logic [DEN_W-1:0]           den_r, rem_r;
  logic [NUM_W-1:0]           quot_r;
  logic                       neg_r;

  logic signed [FORCE_W-1:0]  force_r;
  logic [ASUM_W-1:0]          asum_r;

  // combinational per stage
  logic [CENTER_W-1:0] c0;
  logic [HWIDTH_W-1:0] h0;
  logic [WEIGHT_W-1:0] w0;
  logic [15:0]         ad0;
  logic [55:0]         hd;
  logic [50:0]         yfull;
  logic [2:0]          ti_idx;
  logic [12:0]         tfrac;
  logic [PSI_W-1:0]    t_cur, t_nxt, t_dif;
  logic [29:0]         sub_full;
  logic [PSI_W-1:0]    v6;
  logic [NUM_W-1:0]    mag;
  logic [DEN_W:0]      rsh;
  logic                qbit;
  logic [DEN_W-1:0]    rem_sub;
  logic signed [FORCE_W-1:0] force_sat;

  assign wr_addr = KI_W'(in_kernel_index);
  assign stat.pipe_empty = (vld_r == '0);
  assign out_force_res      = force_r;
  assign out_activation_sum = asum_r;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      kmem[wr_addr] <= {in_center, in_width, in_weight};
    end
    if (cmd.issue) begin
      rd_q <= kmem[rd_addr];
    end
  end

  always_comb begin
    {c0, h0, w0} = rd_q;
    ad0      = (phase_r >= c0) ? (phase_r - c0) : (c0 - phase_r);
    hd       = h2_r * d2_r;
    yfull    = a3_r * LOG2E_Q16;
    ti_idx   = r4_r[15:13];
    tfrac    = r4_r[12:0];
    t_cur    = pow2_val({1'b0, ti_idx});
    t_nxt    = pow2_val({1'b0, ti_idx} + 4'd1);
    t_dif    = t_cur - t_nxt;
    sub_full = t_dif * tfrac;
    v6       = ti5_r - sub5_r;
  end

  // activation pipeline
  always_ff @(posedge clk) begin
    // stage 1: |x - c|
    ad1_r <= ad0;
    h1_r  <= h0;
    w1_r  <= w0;
    // stage 2: d^2
    d2_r  <= ad1_r * ad1_r;
    h2_r  <= h1_r;
    w2_r  <= w1_r;
    // stage 3: h * d^2 to Q.16
    a3_r  <= hd[55:22];
    w3_r  <= w2_r;
    // stage 4: scale by log2(e), split into shift and fraction
    fl4_r <= (yfull[50:32] >= FLUSH_SHIFT);
    n4_r  <= yfull[36:32];
    r4_r  <= yfull[31:16];
    w4_r  <= w3_r;
    // stage 5: linear interpolation product
    ti5_r  <= t_cur;
    sub5_r <= sub_full[29:13];
    n5_r   <= n4_r;
    fl5_r  <= fl4_r;
    w5_r   <= w4_r;
    // stage 6: activation
    psi6_r <= fl5_r ? '0 : (v6 >> n5_r);
    w6_r   <= w5_r;
    // stage 7: weighted activation
    pw7_r  <= $signed({1'b0, psi6_r}) * w6_r;
    psi7_r <= psi6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], cmd.issue};
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (cmd.eval_start) begin
      phase_r <= in_phase;
      num_r   <= '0;
      sum_r   <= '0;
    end else if (vld_r[NSTG-1]) begin
      num_r <= num_r + NUM_W'(pw7_r);
      sum_r <= sum_r + SUM_W'(psi7_r);
    end
  end

  // restoring divider, one quotient bit per step
  always_comb begin
    mag     = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    rsh     = {rem_r, quot_r[NUM_W-1]};
    qbit    = (rsh >= {1'b0, den_r});
    rem_sub = qbit ? DEN_W'(rsh - {1'b0, den_r}) : rsh[DEN_W-1:0];
    if (neg_r) begin
      force_sat = (quot_r > Q_NEG_LIM) ? FORCE_W'(32'sh8000_0000)
                                       : -$signed(quot_r[FORCE_W-1:0]);
    end else begin
      force_sat = (quot_r > Q_POS_LIM) ? FORCE_W'(32'sh7FFF_FFFF)
                                       : $signed(quot_r[FORCE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      den_r  <= DEN_W'(sum_r) + DEN_W'(1);
      rem_r  <= '0;
      quot_r <= mag;
      neg_r  <= num_r[NUM_W-1];
    end else if (cmd.div_step) begin
      rem_r  <= rem_sub;
      quot_r <= {quot_r[NUM_W-2:0], qbit};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      force_r <= force_sat;
      asum_r  <= ASUM_W'(sum_r);
    end
  end

endmodule
